// ===== rtl/core/nimh_delta_v_charge_controller_macros.svh =====
// Assertion macros for the NiMH delta-V charge controller.
`ifndef NIMH_DELTA_V_CHARGE_CONTROLLER_MACROS_SVH
`define NIMH_DELTA_V_CHARGE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

`define NDV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define NDV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NDV_ASSERT_SAME(lbl, ante, cons, msg)

`define NDV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ndv_pkg.sv =====
// Shared types, constants and helpers for the NiMH delta-V charge controller.
package ndv_pkg;

    localparam int SPS_LOG2 = 3;
    localparam int SAMPLES_PER_SECOND = 1 << SPS_LOG2;
    localparam int SUM_W = 10 + SPS_LOG2;
    localparam int CNT_W = SPS_LOG2;

    localparam logic [7:0] SOFT_DUTY = 8'd76;
    localparam logic [7:0] TRICKLE_DUTY = 8'd16;
    localparam logic [7:0] FAST_DUTY = 8'd255;
    localparam logic [7:0] OFF_DUTY = 8'd0;

    localparam logic [15:0] CHARGE_MAX = 16'hFFFF;
    localparam logic [11:0] PLATEAU_MAX = 12'hFFF;

    localparam logic [1:0] CMD_LOADED = 2'd0;
    localparam logic [1:0] CMD_OPEN = 2'd1;
    localparam logic [1:0] CMD_SELF_TEST = 2'd2;

    localparam logic [2:0] CODE_STANDBY = 3'd0;
    localparam logic [2:0] CODE_COOL = 3'd1;
    localparam logic [2:0] CODE_SOFT = 3'd2;
    localparam logic [2:0] CODE_FAST = 3'd3;
    localparam logic [2:0] CODE_TRICKLE = 3'd4;
    localparam logic [2:0] CODE_ERROR = 3'd5;

    localparam logic [2:0] REG_DISCONNECT = 3'd0;
    localparam logic [2:0] REG_SELF_TEST = 3'd1;
    localparam logic [2:0] REG_OVER_VOLTAGE = 3'd2;
    localparam logic [2:0] REG_DELTA_DROP = 3'd3;
    localparam logic [2:0] REG_PLATEAU = 3'd4;
    localparam logic [2:0] REG_FAST_TIME = 3'd5;
    localparam logic [2:0] REG_SOFT_TIME = 3'd6;
    localparam logic [2:0] REG_COOL_TIME = 3'd7;

    localparam logic [9:0] RST_DISCONNECT = 10'd100;
    localparam logic [9:0] RST_SELF_TEST = 10'd500;
    localparam logic [9:0] RST_OVER_VOLTAGE = 10'd950;
    localparam logic [9:0] RST_DELTA_DROP = 10'd3;
    localparam logic [11:0] RST_PLATEAU = 12'd900;
    localparam logic [15:0] RST_FAST_TIME = 16'd10800;
    localparam logic [15:0] RST_SOFT_TIME = 16'd240;
    localparam logic [7:0] RST_COOL_TIME = 8'd2;

    typedef enum logic [5:0] {
        PH_STANDBY = 6'b000001,
        PH_COOL    = 6'b000010,
        PH_SOFT    = 6'b000100,
        PH_FAST    = 6'b001000,
        PH_TRICKLE = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [9:0]  disconnect_level;
        logic [9:0]  self_test_level;
        logic [9:0]  over_voltage_level;
        logic [9:0]  delta_drop;
        logic [11:0] plateau_limit;
        logic [15:0] fast_time_limit;
        logic [15:0] soft_time_limit;
        logic [7:0]  cool_time_limit;
    } ndv_cfg_t;

    typedef struct packed {
        logic [2:0] charger_phase;
        logic [7:0] drive_duty;
        logic       led_level;
        logic       window_done;
        logic [9:0] average_value;
        logic [9:0] peak_value;
    } ndv_result_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_STANDBY: code = CODE_STANDBY;
            PH_COOL:    code = CODE_COOL;
            PH_SOFT:    code = CODE_SOFT;
            PH_FAST:    code = CODE_FAST;
            PH_TRICKLE: code = CODE_TRICKLE;
            default:    code = CODE_ERROR;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] phase_duty(input phase_t ph);
        logic [7:0] duty;
        unique case (ph)
            PH_SOFT:    duty = SOFT_DUTY;
            PH_FAST:    duty = FAST_DUTY;
            PH_TRICKLE: duty = TRICKLE_DUTY;
            default:    duty = OFF_DUTY;
        endcase
        return duty;
    endfunction

endpackage

// ===== rtl/core/ndv_cfg.sv =====
// Configuration register file for the charge controller thresholds and limits.
module ndv_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output ndv_pkg::ndv_cfg_t cfg
);
    import ndv_pkg::*;

    ndv_cfg_t cfg_reg;
    ndv_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DISCONNECT:   cfg_next.disconnect_level = cfg_data[9:0];
                REG_SELF_TEST:    cfg_next.self_test_level = cfg_data[9:0];
                REG_OVER_VOLTAGE: cfg_next.over_voltage_level = cfg_data[9:0];
                REG_DELTA_DROP:   cfg_next.delta_drop = cfg_data[9:0];
                REG_PLATEAU:      cfg_next.plateau_limit = cfg_data[11:0];
                REG_FAST_TIME:    cfg_next.fast_time_limit = cfg_data;
                REG_SOFT_TIME:    cfg_next.soft_time_limit = cfg_data;
                REG_COOL_TIME:    cfg_next.cool_time_limit = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disconnect_level <= RST_DISCONNECT;
            cfg_reg.self_test_level <= RST_SELF_TEST;
            cfg_reg.over_voltage_level <= RST_OVER_VOLTAGE;
            cfg_reg.delta_drop <= RST_DELTA_DROP;
            cfg_reg.plateau_limit <= RST_PLATEAU;
            cfg_reg.fast_time_limit <= RST_FAST_TIME;
            cfg_reg.soft_time_limit <= RST_SOFT_TIME;
            cfg_reg.cool_time_limit <= RST_COOL_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/ndv_core.sv =====
// Charge sequencer state and combinational per-sample update.
`include "nimh_delta_v_charge_controller_macros.svh"

module ndv_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           command,
    input  logic [9:0]           sample_value,
    input  ndv_pkg::ndv_cfg_t    cfg,
    output ndv_pkg::ndv_result_t result
);
    import ndv_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [9:0]         peak_reg;
    logic [9:0]         peak_next;
    logic [11:0]        plateau_reg;
    logic [11:0]        plateau_next;
    logic [15:0]        charge_reg;
    logic [15:0]        charge_next;
    logic               led_reg;
    logic               led_next;
    logic [9:0]         average_reg;
    logic [9:0]         average_next;

    phase_t             phase_cur;
    logic               charging;
    logic               loaded;
    logic               wrap;
    logic               done;
    logic [SUM_W-1:0]   sum_add;
    logic [9:0]         avg;
    logic [15:0]        charge_bump;
    logic               trick_d;
    logic [9:0]         peak_d;
    logic [11:0]        plateau_d;

    always_comb
    begin
        unique case (phase_reg)
            PH_STANDBY, PH_COOL, PH_SOFT, PH_FAST, PH_TRICKLE, PH_ERROR:
                phase_cur = phase_reg;
            default:
                phase_cur = PH_ERROR;
        endcase
    end

    assign charging = (phase_cur == PH_COOL) || (phase_cur == PH_SOFT)
                   || (phase_cur == PH_FAST) || (phase_cur == PH_TRICKLE);
    assign loaded = (command == CMD_LOADED) && charging;
    assign sum_add = sum_reg + SUM_W'(sample_value);
    assign wrap = (count_reg == CNT_W'(SAMPLES_PER_SECOND - 1));
    assign avg = sum_add[SUM_W-1:SPS_LOG2];
    assign charge_bump = (charge_reg != CHARGE_MAX) ? charge_reg + 16'd1 : charge_reg;

    always_comb
    begin
        trick_d = (plateau_reg > cfg.plateau_limit) || (avg > cfg.over_voltage_level);
        peak_d = peak_reg;
        plateau_d = plateau_reg;
        if (avg > peak_reg)
        begin
            peak_d = avg;
            plateau_d = '0;
        end
        else if ((peak_reg - avg) > cfg.delta_drop)
        begin
            trick_d = 1'b1;
        end
        else if (plateau_reg != PLATEAU_MAX)
        begin
            plateau_d = plateau_reg + 12'd1;
        end
    end

    always_comb
    begin
        phase_next = phase_cur;
        sum_next = sum_reg;
        count_next = count_reg;
        peak_next = peak_reg;
        plateau_next = plateau_reg;
        charge_next = charge_reg;
        average_next = average_reg;
        led_next = led_reg;
        done = 1'b0;

        unique case (phase_cur)
            PH_STANDBY: led_next = 1'b1;
            PH_COOL:    led_next = 1'b0;
            PH_TRICKLE: led_next = 1'b1;
            PH_ERROR:   led_next = ~led_reg;
            default:    led_next = led_reg;
        endcase

        if (loaded)
        begin
            if (phase_cur == PH_FAST)
            begin
                led_next = ~led_next;
            end
            if (wrap)
            begin
                sum_next = '0;
                count_next = '0;
                average_next = avg;
                done = 1'b1;
                unique case (phase_cur)
                    PH_COOL:
                    begin
                        charge_next = charge_bump;
                        if (charge_bump > {8'd0, cfg.cool_time_limit})
                        begin
                            phase_next = PH_SOFT;
                        end
                    end
                    PH_SOFT:
                    begin
                        led_next = ~led_next;
                        charge_next = charge_bump;
                        peak_next = peak_d;
                        plateau_next = plateau_d;
                        if (charge_bump > cfg.soft_time_limit)
                        begin
                            phase_next = PH_FAST;
                        end
                        else if (trick_d)
                        begin
                            phase_next = PH_TRICKLE;
                        end
                    end
                    PH_FAST:
                    begin
                        charge_next = charge_bump;
                        peak_next = peak_d;
                        plateau_next = plateau_d;
                        if (trick_d || (charge_bump > cfg.fast_time_limit))
                        begin
                            phase_next = PH_TRICKLE;
                        end
                    end
                    default:
                    begin
                        charge_next = charge_bump;
                        peak_next = peak_d;
                        plateau_next = plateau_d;
                    end
                endcase
            end
            else
            begin
                sum_next = sum_add;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (command == CMD_OPEN)
        begin
            if ((phase_cur == PH_STANDBY) && (sample_value >= cfg.disconnect_level))
            begin
                phase_next = PH_COOL;
            end
            else if ((phase_cur == PH_TRICKLE) && (sample_value < cfg.disconnect_level))
            begin
                phase_next = PH_STANDBY;
                peak_next = '0;
                plateau_next = '0;
                charge_next = '0;
                sum_next = '0;
                count_next = '0;
            end
        end
        else if (command == CMD_SELF_TEST)
        begin
            if ((phase_cur == PH_STANDBY) && (sample_value < cfg.self_test_level))
            begin
                phase_next = PH_ERROR;
            end
        end
    end

    assign result.charger_phase = phase_code(phase_next);
    assign result.drive_duty = phase_duty(phase_next);
    assign result.led_level = led_next;
    assign result.window_done = done;
    assign result.average_value = average_next;
    assign result.peak_value = peak_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STANDBY;
            sum_reg <= '0;
            count_reg <= '0;
            peak_reg <= '0;
            plateau_reg <= '0;
            charge_reg <= '0;
            led_reg <= 1'b0;
            average_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sum_reg <= sum_next;
            count_reg <= count_next;
            peak_reg <= peak_next;
            plateau_reg <= plateau_next;
            charge_reg <= charge_next;
            led_reg <= led_next;
            average_reg <= average_next;
        end
    end

    `NDV_ASSERT_NEXT(a_error_sticky, phase_reg == PH_ERROR, phase_reg == PH_ERROR, "error phase left")
    `NDV_ASSERT_NEXT(a_window_clears, accept && done, count_reg == '0 && sum_reg == '0, "window not cleared")
    `NDV_ASSERT_SAME(a_standby_clean, phase_reg == PH_STANDBY, charge_reg == '0 && peak_reg == '0, "standby holds charge state")

endmodule

// ===== rtl/core/ndv_skid.sv =====
// Two-entry output register with skid stage for result beats.
`include "nimh_delta_v_charge_controller_macros.svh"

module ndv_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ndv_pkg::ndv_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ndv_pkg::ndv_result_t out_data
);
    import ndv_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    ndv_result_t out_reg;
    ndv_result_t out_next;
    ndv_result_t skid_reg;
    ndv_result_t skid_next;
    logic        push;
    logic        take;

    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign push = in_valid && !skid_valid_reg;
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next = out_reg;
        skid_next = skid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next = skid_reg;
                out_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

    `NDV_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `NDV_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg, "skid beat not moved")

endmodule

// ===== rtl/core/nimh_delta_v_charge_controller.sv =====
// Top level of the NiMH negative delta-V charge controller. Each accepted
// beat (command plus 10-bit ADC sample) is processed in the cycle it is
// accepted and yields exactly one result beat, registered at the output; one
// beat can be accepted every clock cycle, and a two-entry output stage lets
// input keep flowing for one beat while a result waits. The sequencer walks
// standby, cool-down, soft, fast and trickle charge, with an error phase left
// only by reset. Eight loaded samples form one second, whose average drives
// peak tracking, delta-V, over-voltage, plateau and phase-time termination.
// The user must write thresholds and limits through the configuration port
// (always ready) only while no beats are in flight; the block does not check.
module nimh_delta_v_charge_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [9:0]  sample_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  charger_phase,
    output logic [7:0]  drive_duty,
    output logic        led_level,
    output logic        window_done,
    output logic [9:0]  average_value,
    output logic [9:0]  peak_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ndv_pkg::*;

    ndv_cfg_t    cfg;
    ndv_result_t step_result;
    ndv_result_t out_data;
    logic        accept;

    assign accept = in_valid && !in_stall;

    ndv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ndv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .sample_value (sample_value),
        .cfg          (cfg),
        .result       (step_result)
    );

    ndv_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (step_result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign charger_phase = out_data.charger_phase;
    assign drive_duty = out_data.drive_duty;
    assign led_level = out_data.led_level;
    assign window_done = out_data.window_done;
    assign average_value = out_data.average_value;
    assign peak_value = out_data.peak_value;

endmodule
